[rtl/core/rccr_pkg.sv]
// ----------------------------------------------------------------------------
// rccr_pkg
// Shared types and constants for the correlation ranger.
// ----------------------------------------------------------------------------
package rccr_pkg;

  localparam int RX_DEPTH_DEF    = 256;
  localparam int TX_DEPTH_DEF    = 4096;
  localparam int AVG_DEPTH_DEF   = 64;
  localparam int CHECK_SPAN_DEF  = 2;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int MAX_DECIM   = 16;
  localparam int DIST_W      = 46;
  localparam int PEAK_W      = 32;
  localparam int LAG_W       = 14;
  localparam int PTOT_W      = 38;
  localparam int LTOT_W      = 20;
  localparam int ACC_W       = 48;
  localparam int POW_W       = 64;

  localparam logic [1:0] MODE_RX  = 2'd0;
  localparam logic [1:0] MODE_TX  = 2'd1;
  localparam logic [1:0] MODE_EST = 2'd2;

  localparam logic [1:0] REG_RX_LENGTH = 2'd0;
  localparam logic [1:0] REG_DECIM     = 2'd1;
  localparam logic [1:0] REG_AVG       = 2'd2;
  localparam logic [1:0] REG_SCALE     = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CENTER,
    ST_LAG,
    ST_MAC,
    ST_DRAIN,
    ST_POWER,
    ST_SQRT,
    ST_TRACK,
    ST_LOCK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic setup;
    logic center;
    logic lag_init;
    logic mac_start;
    logic mac_step;
    logic power;
    logic sqrt_init;
    logic sqrt_step;
    logic track;
    logic lock;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic center_done;
    logic mac_last;
    logic lag_last;
    logic sqrt_done;
  } sts_t;

endpackage

[rtl/core/rccr_ram.sv]
// ----------------------------------------------------------------------------
// rccr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module rccr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/rccr_ctrl.sv]
// ----------------------------------------------------------------------------
// rccr_ctrl
// Estimate sequencer: lag loop, sample loop, root, tracking, result.
// ----------------------------------------------------------------------------
module rccr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             locked,
  input  logic             out_stall,
  input  rccr_pkg::sts_t   sts,
  output rccr_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             out_valid
);
  import rccr_pkg::*;

  state_t state_r, state_nxt;
  logic [1:0] drain_r, drain_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = locked ? ST_CENTER : ST_LAG;
      ST_CENTER: if (sts.center_done) state_nxt = ST_LAG;
      ST_LAG:    state_nxt = ST_MAC;
      ST_MAC: begin
        if (sts.mac_last) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 2'd1;
        if (drain_r == 2'd2) state_nxt = ST_POWER;
      end
      ST_POWER:  state_nxt = sts.lag_last ? ST_SQRT : ST_MAC;
      ST_SQRT:   if (sts.sqrt_done) state_nxt = ST_TRACK;
      ST_TRACK:  state_nxt = ST_LOCK;
      ST_LOCK:   state_nxt = ST_OUT;
      ST_OUT:    if (!out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_SETUP:  cmd.setup = 1'b1;
      ST_CENTER: cmd.center = 1'b1;
      ST_LAG:    cmd.lag_init = 1'b1;
      ST_MAC:    cmd.mac_step = 1'b1;
      ST_POWER: begin
        cmd.power     = 1'b1;
        cmd.mac_start = 1'b1;
        cmd.sqrt_init = sts.lag_last;
      end
      ST_SQRT:   cmd.sqrt_step = 1'b1;
      ST_TRACK:  cmd.track = 1'b1;
      ST_LOCK:   cmd.lock = 1'b1;
      ST_OUT:    cmd.emit = 1'b1;
      default:   cmd = '0;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
endmodule

[rtl/core/rccr_dp.sv]
// ----------------------------------------------------------------------------
// rccr_dp
// Correlation datapath: sample stores, complex MAC, root, tracking ring.
// ----------------------------------------------------------------------------
module rccr_dp #(
  parameter int RX_DEPTH    = rccr_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH    = rccr_pkg::TX_DEPTH_DEF,
  parameter int AVG_DEPTH   = rccr_pkg::AVG_DEPTH_DEF,
  parameter int CHECK_SPAN  = rccr_pkg::CHECK_SPAN_DEF,
  parameter int SAMPLE_BITS = rccr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_rx,
  input  logic                              wr_tx,
  input  logic [11:0]                       wr_index,
  input  logic signed [SAMPLE_BITS-1:0]     wr_re,
  input  logic signed [SAMPLE_BITS-1:0]     wr_im,
  input  logic [8:0]                        rx_length,
  input  logic [4:0]                        decimation,
  input  logic [6:0]                        average_count,
  input  logic [31:0]                       distance_scale,
  input  rccr_pkg::cmd_t                    cmd,
  output rccr_pkg::sts_t                    sts,
  output logic                              locked,
  output logic signed [rccr_pkg::DIST_W-1:0] distance,
  output logic [rccr_pkg::PEAK_W-1:0]       peak,
  output logic signed [rccr_pkg::LAG_W-1:0] lag
);
  import rccr_pkg::*;

  localparam int RXA = $clog2(RX_DEPTH);
  localparam int TXA = $clog2(TX_DEPTH);
  localparam int AVA = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int TLW = $clog2(TX_DEPTH) + 1;
  localparam int RLW = $clog2(RX_DEPTH) + 1;
  localparam int SW  = 2 * SAMPLE_BITS;
  localparam int NW  = $clog2(AVG_DEPTH) + 1;
  localparam int LW  = TLW + 1;

  // ---- stores ----
  logic [RXA-1:0] rx_raddr;
  logic [TXA-1:0] tx_raddr;
  logic [SW-1:0]  rx_rdata, tx_rdata;
  logic [RXA-1:0] rx_waddr;
  logic [TXA-1:0] tx_waddr;
  logic rx_hit, tx_hit;

  assign rx_hit   = ({20'd0, wr_index} < 32'(RX_DEPTH));
  assign tx_hit   = ({20'd0, wr_index} < 32'(TX_DEPTH));
  assign rx_waddr = RXA'(wr_index);
  assign tx_waddr = TXA'(wr_index);

  rccr_ram #(.WIDTH(SW), .DEPTH(RX_DEPTH)) u_rx (
    .clk(clk), .we(wr_rx && rx_hit), .waddr(rx_waddr), .wdata({wr_re, wr_im}),
    .raddr(rx_raddr), .rdata(rx_rdata));
  rccr_ram #(.WIDTH(SW), .DEPTH(TX_DEPTH)) u_tx (
    .clk(clk), .we(wr_tx && tx_hit), .waddr(tx_waddr), .wdata({wr_re, wr_im}),
    .raddr(tx_raddr), .rdata(tx_rdata));

  // ---- setup ----
  logic [RLW-1:0] rl_r;
  logic [4:0]     dec_r;
  logic [TLW-1:0] tl_r;
  logic [NW-1:0]  n_r;
  logic [RLW-1:0] rl_c;
  logic [4:0]     dec_c, dec_lim;
  logic [NW-1:0]  n_c;
  logic [TLW+4:0] prod_c;

  always_comb begin
    if (rx_length == 9'd0) rl_c = RLW'(1);
    else if ({23'd0, rx_length} > 32'(RX_DEPTH)) rl_c = RLW'(RX_DEPTH);
    else rl_c = RLW'(rx_length);
    if (decimation == 5'd0) dec_c = 5'd1;
    else if (decimation > 5'(MAX_DECIM)) dec_c = 5'(MAX_DECIM);
    else dec_c = decimation;
    // largest decimation keeping rl*dec within the transmit store
    dec_lim = 5'd1;
    for (int d = 2; d <= MAX_DECIM; d++) begin
      if ((32'(rl_c) * 32'(d)) <= 32'(TX_DEPTH)) dec_lim = 5'(d);
    end
    prod_c = (TLW+5)'(rl_c) * (TLW+5)'(dec_c);
    if (32'(prod_c) > 32'(TX_DEPTH)) begin
      dec_c  = dec_lim;
      prod_c = (TLW+5)'(rl_c) * (TLW+5)'(dec_c);
    end
    if (average_count == 7'd0) n_c = NW'(1);
    else if ({25'd0, average_count} > 32'(AVG_DEPTH)) n_c = NW'(AVG_DEPTH);
    else n_c = NW'(average_count);
  end

  // ---- tracking state ----
  logic [PTOT_W-1:0]        ptot_r;
  logic signed [LTOT_W-1:0] ltot_r;
  logic [AVA-1:0]           rptr_r;
  logic                     lock_r;
  logic [AVG_DEPTH-1:0]     ring_vld_r;
  logic [PEAK_W+LW-1:0]     ring_rdata;
  logic [PEAK_W-1:0]        peak_old;
  logic signed [LW-1:0]     lag_old;

  // ---- center division (restoring, one bit a cycle) ----
  logic [LTOT_W:0]   cnum_r;
  logic [LTOT_W:0]   cquo_r;
  logic [NW:0]       crem_r;
  logic [4:0]        ccnt_r;
  logic              cneg_r;
  logic [NW:0]       crem_sh;
  logic signed [LW-1:0] cval;
  logic signed [LTOT_W+1:0] cq_s;

  always_comb begin
    crem_sh = {crem_r[NW-1:0], cnum_r[LTOT_W]};
    cq_s = cneg_r ? -$signed({1'b0, cquo_r}) : $signed({1'b0, cquo_r});
    if (cq_s < 0) cval = '0;
    else if (cq_s > $signed((LTOT_W+2)'(tl_r) - 1)) cval = LW'(tl_r) - LW'(1);
    else cval = LW'(cq_s);
  end

  // ---- lag / sample loops ----
  logic signed [LW-1:0] s_r, last_r, best_lag_r;
  logic [TLW-1:0]       p_r;
  logic [RLW-1:0]       j_r;
  logic                 vld1_r, vld2_r;
  logic signed [SAMPLE_BITS-1:0] a, b, c, d;
  logic signed [SW:0]   ac, bd, ad, bc;
  logic signed [SW:0]   pr_re_r, pr_im_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic [ACC_W-1:0]     ur, ui;
  logic [POW_W-1:0]     pw_re_r, pw_im_r, best_r;
  logic [POW_W-1:0]     pw;
  logic [TLW-1:0]       p_next;
  logic signed [LW-1:0] s_base;
  logic signed [LW:0]   base_c;

  assign rx_raddr = RXA'(j_r);
  assign tx_raddr = TXA'(p_r);
  assign {a, b} = rx_rdata;
  assign {c, d} = tx_rdata;
  assign ac = a * c;
  assign bd = b * d;
  assign ad = a * d;
  assign bc = b * c;

  always_comb begin
    p_next = p_r + TLW'(dec_r);
    if (p_next >= tl_r) p_next = p_next - tl_r;
    // base index for the first sample of the lag about to start: (-s) mod tl
    s_base = cmd.power ? s_r + LW'(1) : s_r;
    base_c = -$signed({s_base[LW-1], s_base});
    for (int i = 0; i < CHECK_SPAN + 2; i++) begin
      if (base_c < 0) base_c = base_c + $signed((LW+1)'(tl_r));
      else if (base_c >= $signed((LW+1)'(tl_r))) base_c = base_c - $signed((LW+1)'(tl_r));
    end
    ur = acc_re_r[ACC_W-1] ? ACC_W'(-acc_re_r) : ACC_W'(acc_re_r);
    ui = acc_im_r[ACC_W-1] ? ACC_W'(-acc_im_r) : ACC_W'(acc_im_r);
    pw = pw_re_r + pw_im_r;
  end

  // ---- square root (one result bit a cycle) ----
  logic [POW_W-1:0] sq_v_r, sq_r_r, sq_bit_r;
  logic [POW_W-1:0] sq_rb;
  assign sq_rb = sq_r_r + sq_bit_r;

  // ---- distance multiply ----
  logic signed [LW-1:0]  lag_o_r;
  logic [PEAK_W-1:0]     pk_r;
  logic signed [DIST_W-1:0] dist_r;
  logic [PTOT_W-1:0]     ptot_new;
  logic signed [LTOT_W-1:0] ltot_new;
  logic [PTOT_W+NW-1:0]  pkn;
  logic signed [PTOT_W+NW+1:0] diff;
  logic [PTOT_W+NW+1:0]  adiff;
  logic [PTOT_W+NW+5:0]  adiff10;

  rccr_ram #(.WIDTH(PEAK_W + LW), .DEPTH(AVG_DEPTH)) u_ring (
    .clk(clk), .we(cmd.track), .waddr(rptr_r), .wdata({pk_r, lag_o_r}),
    .raddr(rptr_r), .rdata(ring_rdata));

  always_comb begin
    if (ring_vld_r[rptr_r]) begin
      {peak_old, lag_old} = ring_rdata;
    end else begin
      peak_old = '0;
      lag_old  = '0;
    end
  end

  always_comb begin
    ptot_new = ptot_r - PTOT_W'(peak_old) + PTOT_W'(pk_r);
    ltot_new = LTOT_W'(ltot_r - LTOT_W'(lag_old) + LTOT_W'(lag_o_r));
    pkn = (PTOT_W+NW)'(pk_r) * (PTOT_W+NW)'(n_r);
    diff = $signed({2'b0, ptot_r}) - $signed({2'b0, pkn});
    adiff = diff[PTOT_W+NW+1] ? (PTOT_W+NW+2)'(-diff) : (PTOT_W+NW+2)'(diff);
    adiff10 = ((PTOT_W+NW+6)'(adiff) << 3) + ((PTOT_W+NW+6)'(adiff) << 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      ptot_r <= '0;
      ltot_r <= '0;
      rptr_r <= '0;
      lock_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= cmd.mac_step;
      vld2_r <= vld1_r;
      if (cmd.track) begin
        ptot_r <= ptot_new;
        ltot_r <= ltot_new;
        ring_vld_r[rptr_r] <= 1'b1;
        if ((NW)'(rptr_r) + NW'(1) >= n_r) rptr_r <= '0;
        else rptr_r <= rptr_r + AVA'(1);
      end
      if (cmd.setup && ((NW)'(rptr_r) >= n_c)) rptr_r <= '0;
      if (cmd.lock) begin
        lock_r <= (ptot_r != '0) && (adiff10 < (PTOT_W+NW+6)'(ptot_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rl_r  <= rl_c;
      dec_r <= dec_c;
      tl_r  <= TLW'(prod_c);
      n_r   <= n_c;
      best_r <= '0;
      s_r    <= '0;
      last_r <= LW'(TLW'(prod_c)) - LW'(1);
      // |t|*2 + n for half-away rounding; divide by 2n
      cneg_r <= ltot_r[LTOT_W-1];
      cnum_r <= (LTOT_W+1)'(ltot_r[LTOT_W-1] ? -(LTOT_W+1)'($signed(ltot_r))
                                              : (LTOT_W+1)'(ltot_r));
      crem_r <= '0;
      cquo_r <= '0;
      ccnt_r <= '0;
    end
    if (cmd.center) begin
      if (ccnt_r == 5'd0) begin
        cnum_r <= (cnum_r << 1) + (LTOT_W+1)'(n_r);
        ccnt_r <= 5'd1;
      end else begin
        cnum_r <= cnum_r << 1;
        ccnt_r <= ccnt_r + 5'd1;
        if (crem_sh >= ((NW+1)'(n_r) << 1)) begin
          crem_r <= crem_sh - ((NW+1)'(n_r) << 1);
          cquo_r <= {cquo_r[LTOT_W-1:0], 1'b1};
        end else begin
          crem_r <= crem_sh;
          cquo_r <= {cquo_r[LTOT_W-1:0], 1'b0};
        end
      end
    end
    if (sts.center_done && cmd.center) begin
      s_r        <= cval - LW'(CHECK_SPAN);
      last_r     <= cval + LW'(CHECK_SPAN);
      best_lag_r <= cval - LW'(CHECK_SPAN);
    end
    if (cmd.setup) best_lag_r <= '0;
    if (cmd.lag_init || cmd.mac_start) begin
      j_r      <= '0;
      p_r      <= TLW'(base_c);
      acc_re_r <= '0;
      acc_im_r <= '0;
    end
    if (cmd.mac_step) begin
      j_r <= j_r + RLW'(1);
      p_r <= p_next;
    end
    if (vld1_r) begin
      pr_re_r <= ac + bd;
      pr_im_r <= ad - bc;
    end
    if (vld2_r) begin
      acc_re_r <= acc_re_r + ACC_W'(pr_re_r);
      acc_im_r <= acc_im_r + ACC_W'(pr_im_r);
    end
    pw_re_r <= ur[31:0] * ur[31:0];
    pw_im_r <= ui[31:0] * ui[31:0];
    if (cmd.power) begin
      if (pw > best_r) begin
        best_r     <= pw;
        best_lag_r <= s_r;
      end
      s_r <= s_r + LW'(1);
    end
    if (cmd.sqrt_init) begin
      sq_v_r   <= (pw > best_r) ? pw : best_r;
      sq_r_r   <= '0;
      sq_bit_r <= POW_W'(1) << (POW_W - 2);
      lag_o_r  <= (pw > best_r) ? s_r : best_lag_r;
    end
    if (cmd.sqrt_step) begin
      if (sq_v_r >= sq_rb) begin
        sq_v_r <= sq_v_r - sq_rb;
        sq_r_r <= (sq_r_r >> 1) + sq_bit_r;
      end else begin
        sq_r_r <= sq_r_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
    if (sts.sqrt_done && cmd.sqrt_step) pk_r <= sq_r_r[PEAK_W-1:0];
    if (cmd.track) dist_r <= $signed(lag_o_r) * $signed({1'b0, distance_scale});
  end

  // the square root output is taken on the cycle after the final bit
  assign sts.sqrt_done   = (sq_bit_r == '0);
  assign sts.center_done = (ccnt_r == 5'(LTOT_W + 2));
  assign sts.mac_last    = (j_r + RLW'(1) == rl_r) && cmd.mac_step;
  assign sts.lag_last    = (s_r == last_r);

  assign locked   = lock_r;
  assign distance = dist_r;
  assign peak     = pk_r;
  assign lag      = LAG_W'(lag_o_r);
endmodule

[rtl/core/radar_code_correlation_ranger.sv]
// ----------------------------------------------------------------------------
// radar_code_correlation_ranger
// Cross-correlation range estimator with peak and lag tracking.
// ----------------------------------------------------------------------------
// Samples are written one per cycle, back to back, while in_stall is low.
// An estimate holds the input until its result is taken: a full search has
// rx_length*decimation lags, a locked search 2*CHECK_SPAN+1, each lag one
// complex multiply-accumulate per cycle.
// Reset (synchronous, rst_n low) clears tracking state and registers to
// defaults; the sample stores are not cleared.
module radar_code_correlation_ranger #(
  parameter int RX_DEPTH    = rccr_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH    = rccr_pkg::TX_DEPTH_DEF,
  parameter int AVG_DEPTH   = rccr_pkg::AVG_DEPTH_DEF,
  parameter int CHECK_SPAN  = rccr_pkg::CHECK_SPAN_DEF,
  parameter int SAMPLE_BITS = rccr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_mode,
  input  logic [11:0]                        in_index,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_re,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample_im,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rccr_pkg::DIST_W-1:0] out_distance,
  output logic [rccr_pkg::PEAK_W-1:0]        out_peak,
  output logic signed [rccr_pkg::LAG_W-1:0]  out_lag,
  output logic                               out_locked,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [31:0]                        cfg_data
);
  import rccr_pkg::*;

  logic [8:0]  rx_length_r;
  logic [4:0]  decimation_r;
  logic [6:0]  average_count_r;
  logic [31:0] distance_scale_r;
  logic busy, acc;
  cmd_t cmd;
  sts_t sts;

  assign in_stall  = busy;
  assign cfg_ready = !busy;
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_length_r      <= 9'd256;
      decimation_r     <= 5'd1;
      average_count_r  <= 7'd8;
      distance_scale_r <= 32'd9823599;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RX_LENGTH: rx_length_r      <= cfg_data[8:0];
        REG_DECIM:     decimation_r     <= cfg_data[4:0];
        REG_AVG:       average_count_r  <= cfg_data[6:0];
        REG_SCALE:     distance_scale_r <= cfg_data;
        default:       distance_scale_r <= distance_scale_r;
      endcase
    end
  end

  rccr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(acc && in_mode == MODE_EST),
    .locked(out_locked), .out_stall(out_stall), .sts(sts), .cmd(cmd),
    .busy(busy), .out_valid(out_valid));

  rccr_dp #(
    .RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH), .AVG_DEPTH(AVG_DEPTH),
    .CHECK_SPAN(CHECK_SPAN), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .wr_rx(acc && in_mode == MODE_RX), .wr_tx(acc && in_mode == MODE_TX),
    .wr_index(in_index), .wr_re(in_sample_re), .wr_im(in_sample_im),
    .rx_length(rx_length_r), .decimation(decimation_r),
    .average_count(average_count_r), .distance_scale(distance_scale_r),
    .cmd(cmd), .sts(sts), .locked(out_locked),
    .distance(out_distance), .peak(out_peak), .lag(out_lag));
endmodule

[rtl/core/rccr_checker.sv]
// ----------------------------------------------------------------------------
// rccr_checker
// Port-level checks on the correlation ranger, bound to the top level.
// ----------------------------------------------------------------------------
module rccr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_locked
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during result");
  a_lock_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_locked)) else $error("lock moved");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid) else $error("input withdrawn while stalled");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind radar_code_correlation_ranger rccr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_locked(out_locked));
